### hw/rtl/bsm_pkg.sv
// shared types and constants for the bank switch mapper
`default_nettype none

package bsm_pkg;

  localparam int unsigned PRG_ADDR_BITS_DEF = 19;
  localparam int unsigned CHR_ADDR_BITS_DEF = 18;
  localparam int unsigned MADDR_W           = 19;
  localparam int unsigned CHR_REG_COUNT     = 6;
  localparam int unsigned PRG_REG_COUNT     = 2;
  localparam int unsigned CFG_DATA_W        = 6;
  localparam int unsigned CFG_INDEX_W       = 2;

  localparam logic [5:0] PRG_SIZE_RESET = 6'd32;
  localparam logic [7:0] PRG_BANK_MASK  = 8'h3F;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRG_SIZE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUAD_NT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INIT_HORIZ = 2'd2;

  localparam logic [1:0] MIRROR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIRROR_QUAD_NT    = 2'd2;

  typedef enum logic [2:0] {
    REQ_CPU_RD  = 3'd0,
    REQ_CPU_WR  = 3'd1,
    REQ_PPU_RD  = 3'd2,
    REQ_PPU_WR  = 3'd3,
    REQ_IRQ_CLK = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_ROM = 3'd1,
    TGT_PRG_RAM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_NT_RAM  = 3'd4
  } target_t;

  typedef struct packed {
    logic [7:0]                    bank_select;
    logic [CHR_REG_COUNT-1:0][7:0] chr_bank;
    logic [PRG_REG_COUNT-1:0][5:0] prg_bank;
    logic [7:0]                    ram_protect;
    logic [5:0]                    prg_size;
    logic                          quad_nt;
  } banks_t;

  typedef struct packed {
    target_t              target;
    logic [MADDR_W-1:0]   maddr;
    logic                 store_en;
    logic [7:0]           store_data;
  } xlate_t;

endpackage

`default_nettype wire

### hw/rtl/bsm_xlate.sv
// address translation of one bus request into target memory and offset
`default_nettype none

module bsm_xlate #(
  parameter int unsigned PRG_ADDR_BITS = bsm_pkg::PRG_ADDR_BITS_DEF,
  parameter int unsigned CHR_ADDR_BITS = bsm_pkg::CHR_ADDR_BITS_DEF
) (
  input  wire logic [2:0]     req_type,
  input  wire logic [15:0]    bus_address,
  input  wire logic [7:0]     write_data,
  input  wire bsm_pkg::banks_t banks,
  output bsm_pkg::xlate_t     result
);
  import bsm_pkg::*;

  localparam int unsigned  PRG_MASK_I = (1 << PRG_ADDR_BITS) - 1;
  localparam int unsigned  CHR_MASK_I = (1 << CHR_ADDR_BITS) - 1;
  localparam logic [19:0]  PRG_MASK   = 20'(PRG_MASK_I);
  localparam logic [17:0]  CHR_MASK   = 18'(CHR_MASK_I);

  logic [1:0]  slot;
  logic [6:0]  size8k;
  logic [6:0]  prg_bank;
  logic [19:0] prg_off;
  logic [12:0] chr_a;
  logic [7:0]  chr_reg;
  logic [17:0] chr_off;
  logic        ram_window;
  logic [13:0] pa;

  // prg windows, mode bit swaps $8000 and $C000
  always_comb begin
    slot   = bus_address[14:13];
    size8k = {banks.prg_size, 1'b0};
    if (banks.bank_select[6] && !slot[0]) begin
      slot[1] = ~slot[1];
    end
    unique case (slot)
      2'd0:    prg_bank = {1'b0, banks.prg_bank[0]};
      2'd1:    prg_bank = {1'b0, banks.prg_bank[1]};
      2'd2:    prg_bank = size8k - 7'd2;
      default: prg_bank = size8k - 7'd1;
    endcase
    prg_off = {prg_bank, bus_address[12:0]} & PRG_MASK;
  end

  // chr windows, mode bit swaps the 4KB halves
  always_comb begin
    chr_a = bus_address[12:0] ^ {banks.bank_select[7], 12'd0};
    if (!chr_a[12]) begin
      chr_reg = chr_a[11] ? banks.chr_bank[1] : banks.chr_bank[0];
      chr_off = {chr_reg[7:1], chr_a[10:0]};
    end else begin
      chr_reg = banks.chr_bank[3'(chr_a[11:10]) + 3'd2];
      chr_off = {chr_reg, chr_a[9:0]};
    end
    chr_off = chr_off & CHR_MASK;
  end

  always_comb begin
    ram_window = (bus_address[15:13] == 3'b011) && banks.ram_protect[7];
    pa         = bus_address[13:0];
    result     = '{target: TGT_NONE, maddr: '0, store_en: 1'b0, store_data: 8'd0};
    if (req_type == REQ_CPU_RD) begin
      if (bus_address[15]) begin
        result.target = TGT_PRG_ROM;
        result.maddr  = prg_off[MADDR_W-1:0];
      end else if (ram_window) begin
        result.target = TGT_PRG_RAM;
        result.maddr  = MADDR_W'(bus_address[12:0]);
      end
    end else if (req_type == REQ_CPU_WR) begin
      if (!bus_address[15] && ram_window && !banks.ram_protect[6]) begin
        result.target     = TGT_PRG_RAM;
        result.maddr      = MADDR_W'(bus_address[12:0]);
        result.store_en   = 1'b1;
        result.store_data = write_data;
      end
    end else if (req_type == REQ_PPU_RD || req_type == REQ_PPU_WR) begin
      if (!pa[13]) begin
        if (req_type == REQ_PPU_RD) begin
          result.target = TGT_CHR_ROM;
          result.maddr  = MADDR_W'(chr_off);
        end
      end else if (banks.quad_nt && pa[13:8] != 6'h3F) begin
        result.target = TGT_NT_RAM;
        result.maddr  = MADDR_W'(pa[11:0]);
        if (req_type == REQ_PPU_WR) begin
          result.store_en   = 1'b1;
          result.store_data = write_data;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bank_switch_mapper_with_scanline_irq.sv
// top level of the bank switch mapper with scanline irq counter
`default_nettype none

// Bank switch mapper: takes one bus request (cpu read/write, ppu read/write or irq
// counter clock) per beat and returns one result beat carrying the target memory,
// the mapped byte offset, the ram store strobe and data, and the irq line and
// mirroring mode after the request. A request is accepted every cycle while in_stall is
// low, and its result appears in the single output register on the next cycle.
// in_stall is high only while a result waits in the output register and
// out_stall holds it. Config writes go on the cfg port while the block is idle.
module bank_switch_mapper_with_scanline_irq #(
  parameter int unsigned PRG_ADDR_BITS = bsm_pkg::PRG_ADDR_BITS_DEF,
  parameter int unsigned CHR_ADDR_BITS = bsm_pkg::CHR_ADDR_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [2:0]                     in_req_type,
  input  wire logic [15:0]                    in_bus_address,
  input  wire logic [7:0]                     in_write_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          out_target,
  output logic [bsm_pkg::MADDR_W-1:0]         out_mapped_address,
  output logic                                out_store_enable,
  output logic [7:0]                          out_store_data,
  output logic                                out_irq_line,
  output logic [1:0]                          out_mirror_mode,
  input  wire logic                           cfg_we,
  input  wire logic [bsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bsm_pkg::*;

  logic        in_acc;
  logic        out_valid_r, out_valid_nxt;
  xlate_t      xl;
  xlate_t      res_r;
  logic        irq_line_r;
  logic [1:0]  mirror_r;

  logic [5:0]  prg_size_r;
  logic        quad_nt_r;

  logic [7:0]                    bank_select_r, bank_select_nxt;
  logic [CHR_REG_COUNT-1:0][7:0] chr_bank_r, chr_bank_nxt;
  logic [PRG_REG_COUNT-1:0][5:0] prg_bank_r, prg_bank_nxt;
  logic                          horiz_r, horiz_nxt;
  logic [7:0]                    ram_protect_r, ram_protect_nxt;
  logic [7:0]                    irq_latch_r, irq_latch_nxt;
  logic [7:0]                    irq_cnt_r, irq_cnt_nxt;
  logic                          irq_en_r, irq_en_nxt;
  logic                          irq_reload_r, irq_reload_nxt;
  logic                          irq_pend_r, irq_pend_nxt;

  banks_t      banks;
  logic        reg_wr;
  logic        irq_clk;
  logic        odd;
  logic [2:0]  bsel;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign out_valid_nxt = in_acc || (out_valid_r && out_stall);

  assign banks = '{bank_select: bank_select_r, chr_bank: chr_bank_r, prg_bank: prg_bank_r,
                   ram_protect: ram_protect_r, prg_size: prg_size_r,
                   quad_nt: quad_nt_r};

  bsm_xlate #(
    .PRG_ADDR_BITS(PRG_ADDR_BITS),
    .CHR_ADDR_BITS(CHR_ADDR_BITS)
  ) u_xlate (
    .req_type   (in_req_type),
    .bus_address(in_bus_address),
    .write_data (in_write_data),
    .banks      (banks),
    .result     (xl)
  );

  // register writes and irq counter
  always_comb begin
    reg_wr  = in_acc && in_req_type == REQ_CPU_WR && in_bus_address[15];
    irq_clk = in_acc && in_req_type == REQ_IRQ_CLK;
    odd     = in_bus_address[0];
    bsel    = bank_select_r[2:0];

    bank_select_nxt = bank_select_r;
    chr_bank_nxt    = chr_bank_r;
    prg_bank_nxt    = prg_bank_r;
    horiz_nxt       = horiz_r;
    ram_protect_nxt = ram_protect_r;
    irq_latch_nxt   = irq_latch_r;
    irq_cnt_nxt     = irq_cnt_r;
    irq_en_nxt      = irq_en_r;
    irq_reload_nxt  = irq_reload_r;
    irq_pend_nxt    = irq_pend_r;

    if (reg_wr) begin
      unique case (in_bus_address[14:13])
        2'd0: begin
          if (!odd) begin
            bank_select_nxt = in_write_data;
          end else if (32'(bsel) < CHR_REG_COUNT) begin
            chr_bank_nxt[bsel] = in_write_data;
          end else begin
            prg_bank_nxt[bsel[0]] = 6'(in_write_data & PRG_BANK_MASK);
          end
        end
        2'd1: begin
          if (!odd) horiz_nxt = in_write_data[0];
          else      ram_protect_nxt = in_write_data;
        end
        2'd2: begin
          if (!odd) begin
            irq_latch_nxt = in_write_data;
          end else begin
            irq_cnt_nxt    = 8'd0;
            irq_reload_nxt = 1'b1;
          end
        end
        default: begin
          if (!odd) begin
            irq_en_nxt   = 1'b0;
            irq_pend_nxt = 1'b0;
          end else begin
            irq_en_nxt = 1'b1;
          end
        end
      endcase
    end

    if (irq_clk) begin
      if (irq_cnt_r == 8'd0 || irq_reload_r) begin
        irq_cnt_nxt    = irq_latch_r;
        irq_reload_nxt = 1'b0;
      end else begin
        irq_cnt_nxt = irq_cnt_r - 8'd1;
      end
      if (irq_cnt_nxt == 8'd0 && irq_en_r) begin
        irq_pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_size_r    <= PRG_SIZE_RESET;
      quad_nt_r     <= 1'b0;
      bank_select_r <= '0;
      chr_bank_r    <= '0;
      prg_bank_r    <= '0;
      horiz_r       <= 1'b0;
      ram_protect_r <= '0;
      irq_latch_r   <= '0;
      irq_cnt_r     <= '0;
      irq_en_r      <= 1'b0;
      irq_reload_r  <= 1'b0;
      irq_pend_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PRG_SIZE: prg_size_r <= cfg_wdata;
          CFG_QUAD_NT:  quad_nt_r  <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      bank_select_r <= bank_select_nxt;
      chr_bank_r    <= chr_bank_nxt;
      prg_bank_r    <= prg_bank_nxt;
      horiz_r       <= horiz_nxt;
      ram_protect_r <= ram_protect_nxt;
      irq_latch_r   <= irq_latch_nxt;
      irq_cnt_r     <= irq_cnt_nxt;
      irq_en_r      <= irq_en_nxt;
      irq_reload_r  <= irq_reload_nxt;
      irq_pend_r    <= irq_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r      <= xl;
      irq_line_r <= irq_pend_nxt;
      mirror_r   <= quad_nt_r ? MIRROR_QUAD_NT :
                    (horiz_nxt ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_target         = res_r.target;
  assign out_mapped_address = res_r.maddr;
  assign out_store_enable   = res_r.store_en;
  assign out_store_data     = res_r.store_data;
  assign out_irq_line       = irq_line_r;
  assign out_mirror_mode    = mirror_r;

`ifndef SYNTHESIS
  a_store_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_enable |-> out_target == TGT_PRG_RAM || out_target == TGT_NT_RAM)
    else $error("store beat with non-ram target");

  a_none_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_target == TGT_NONE |-> out_mapped_address == '0 && !out_store_enable)
    else $error("no-target beat carries address or store");

  a_irq_disable: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == REQ_CPU_WR && in_bus_address[15:13] == 3'b111 &&
    !in_bus_address[0] |=> !out_irq_line)
    else $error("irq line high after disable write");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && $past(out_valid_nxt))
    else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
